// ===== src/mhpq_pkg.sv =====
`default_nettype none

package mhpq_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int KEY_W  = 32;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 11;
    localparam int FILL_W = 11;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== src/mhpq_ram.sv =====
`default_nettype none

module mhpq_ram #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT
) (
    input  wire                        aclk,
    input  wire [$clog2(DEPTH)-1:0]    rd_a_addr,
    input  wire [$clog2(DEPTH)-1:0]    rd_b_addr,
    output logic [mhpq_pkg::KEY_W-1:0] rd_a_data,
    output logic [mhpq_pkg::KEY_W-1:0] rd_b_data,
    input  wire                        wr_en,
    input  wire [$clog2(DEPTH)-1:0]    wr_addr,
    input  wire [mhpq_pkg::KEY_W-1:0]  wr_data
);

    logic [mhpq_pkg::KEY_W-1:0] mem [0:DEPTH-1];
    logic [mhpq_pkg::KEY_W-1:0] rd_a_data_reg;
    logic [mhpq_pkg::KEY_W-1:0] rd_b_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data_reg <= mem[rd_a_addr];
        rd_b_data_reg <= mem[rd_b_addr];
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

`default_nettype wire

// ===== src/max_heap_priority_queue.sv =====
// channel   dir  signals                      payload
// s_        in   s_tvalid s_tready s_tdata    op, key
// m_        out  m_tvalid m_tready m_tdata    max_key, status, fill
// cfg_      in   cfg_wr_en cfg_wr_data        capacity
//
// one item at a time; each level of a sift goes through the two-read, one-write
// heap memory: insert sifts up, extract sifts down, peek reads the root only, and
// rejected or no-op items go straight to the output.
// reset clears the fill count and sets capacity to 1024; the heap memory is not cleared.
// a finished result waits in the output register; the block stalls in its last
// state only while that register is still full.
`default_nettype none

module max_heap_priority_queue #(
    parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire [mhpq_pkg::S_TDATA_W-1:0]  s_tdata,   // op[1:0], key[33:2]
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata,   // max_key[31:0], status[33:32], fill[44:34]
    input  wire                            cfg_wr_en,
    input  wire [mhpq_pkg::CAP_W-1:0]      cfg_wr_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LIM_W  = (CNT_W > mhpq_pkg::CAP_W) ? CNT_W : mhpq_pkg::CAP_W;
    localparam int IDX_W  = ADDR_W + 2;
    localparam int KEY_W  = mhpq_pkg::KEY_W;
    localparam int PAD_W  = mhpq_pkg::M_TDATA_W - KEY_W - mhpq_pkg::STAT_W - mhpq_pkg::FILL_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROOT   = 3'd1;
    localparam logic [2:0] S_UP     = 3'd2;
    localparam logic [2:0] S_DOWN   = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [mhpq_pkg::OP_W-1:0]      op_reg, op_next;
    logic [KEY_W-1:0]               key_reg, key_next;
    logic [ADDR_W-1:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [mhpq_pkg::CAP_W-1:0]     cap_reg;
    logic [KEY_W-1:0]               max_key_reg, max_key_next;
    logic [mhpq_pkg::STAT_W-1:0]    status_reg, status_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [mhpq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, wr_addr;
    logic [KEY_W-1:0]  rd_a_data, rd_b_data, wr_data;
    logic              wr_en;

    logic [mhpq_pkg::OP_W-1:0] in_op;
    logic [KEY_W-1:0]          in_key;
    logic [LIM_W-1:0]          cap_ext, limit, count_ext;
    logic                      full, accept;
    logic [ADDR_W-1:0]         ins_pos, ins_up, cur_up, best;
    logic [IDX_W-1:0]          lc_idx, rc_idx, count_idx, best_lc;
    logic                      lc_ok, rc_ok, take_l, take_r;

    assign in_op  = s_tdata[1:0];
    assign in_key = s_tdata[33:2];
    assign accept = s_tvalid && s_tready;

    assign cap_ext   = LIM_W'(cap_reg);
    assign limit     = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
    assign count_ext = LIM_W'(count_reg);
    assign full      = (count_ext >= limit);

    assign ins_pos = ADDR_W'(count_reg);
    assign ins_up  = (ins_pos - ADDR_W'(1)) >> 1;
    assign cur_up  = (pos_reg - ADDR_W'(1)) >> 1;

    // children of the current slot, checked against the fill in a wider index
    assign lc_idx    = {1'b0, pos_reg, 1'b1};
    assign rc_idx    = lc_idx + IDX_W'(1);
    assign count_idx = IDX_W'(count_reg);
    assign lc_ok     = (lc_idx < count_idx);
    assign rc_ok     = (rc_idx < count_idx);
    assign take_l    = lc_ok && ($signed(rd_a_data) > $signed(key_reg));
    assign take_r    = rc_ok && (take_l ? ($signed(rd_b_data) > $signed(rd_a_data))
                                        : ($signed(rd_b_data) > $signed(key_reg)));
    assign best      = take_r ? ADDR_W'(rc_idx) : ADDR_W'(lc_idx);
    assign best_lc   = {1'b0, best, 1'b1};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    mhpq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        max_key_next  = max_key_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_a_addr     = '0;
        rd_b_addr     = '0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = key_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next      = in_op;
                    key_next     = in_key;
                    max_key_next = '0;
                    status_next  = mhpq_pkg::STATUS_OK;
                    state_next   = S_FINISH;
                    priority if (in_op == mhpq_pkg::OP_INSERT) begin
                        if (full) begin
                            status_next = mhpq_pkg::STATUS_OVERFLOW;
                        end else begin
                            count_next = count_reg + CNT_W'(1);
                            pos_next   = ins_pos;
                            if (count_reg == '0) begin
                                state_next = S_PLACE;
                            end else begin
                                rd_a_addr  = ins_up;
                                state_next = S_UP;
                            end
                        end
                    end else if (in_op == mhpq_pkg::OP_EXTRACT ||
                                 in_op == mhpq_pkg::OP_PEEK) begin
                        if (count_reg == '0) begin
                            status_next = mhpq_pkg::STATUS_UNDERFLOW;
                        end else begin
                            rd_a_addr  = '0;
                            rd_b_addr  = ADDR_W'(count_reg - CNT_W'(1));
                            state_next = S_ROOT;
                            if (in_op == mhpq_pkg::OP_EXTRACT) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end else begin
                        status_next = mhpq_pkg::STATUS_OK;
                    end
                end
            end
            S_ROOT: begin
                max_key_next = rd_a_data;
                state_next   = S_FINISH;
                if (op_reg == mhpq_pkg::OP_EXTRACT && count_reg != '0) begin
                    // last entry moves to the root and sinks from there
                    key_next   = rd_b_data;
                    pos_next   = '0;
                    rd_a_addr  = ADDR_W'(1);
                    rd_b_addr  = ADDR_W'(2);
                    state_next = S_DOWN;
                end
            end
            S_UP: begin
                wr_en = 1'b1;
                if ($signed(rd_a_data) < $signed(key_reg)) begin
                    wr_data  = rd_a_data;
                    pos_next = cur_up;
                    if (cur_up == '0) begin
                        state_next = S_PLACE;
                    end else begin
                        rd_a_addr = (cur_up - ADDR_W'(1)) >> 1;
                    end
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_DOWN: begin
                wr_en = 1'b1;
                if (take_l || take_r) begin
                    wr_data   = take_r ? rd_b_data : rd_a_data;
                    pos_next  = best;
                    rd_a_addr = ADDR_W'(best_lc);
                    rd_b_addr = ADDR_W'(best_lc + IDX_W'(1));
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_PLACE: begin
                wr_en      = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, mhpq_pkg::FILL_W'(count_reg),
                                     status_reg, max_key_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= mhpq_pkg::CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        max_key_reg <= max_key_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_overflow_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_op == mhpq_pkg::OP_INSERT && full |=> count_reg == $past(count_reg))
        else $error("rejected insert changed the fill");

    a_extract_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_op == mhpq_pkg::OP_EXTRACT && count_reg != '0
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("extract did not drop the fill by one");

    a_down_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DOWN |-> IDX_W'(pos_reg) < count_idx)
        else $error("sift-down slot outside the heap");

endmodule

`default_nettype wire
